[hdl/mqpp_pkg.sv]
// mqpp_pkg: sizes, opcodes and beat types for the multi-queue priority picker.
// No dependencies; imported by the core.
`default_nettype none

package mqpp_pkg;

   localparam int POOL_DEPTH  = 64;
   localparam int QUEUE_COUNT = 7;
   localparam int STEP_BITS   = 8;
   localparam int HANDLE_BITS = 8;
   localparam int TYPE_BITS   = 4;
   localparam int QSEL_BITS   = 3;
   localparam int FLAG_BITS   = 7;

   // only queues that exist get a non-empty flag
   localparam int FLAG_COUNT = (QUEUE_COUNT < FLAG_BITS) ? QUEUE_COUNT : FLAG_BITS;

   localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CNT_W = $clog2(POOL_DEPTH + 1);

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TAKE = 1'b1;

   typedef struct packed {
      logic                   operation;
      logic [QSEL_BITS-1:0]   queue_select;
      logic [HANDLE_BITS-1:0] job_handle;
      logic [STEP_BITS-1:0]   job_step;
      logic [TYPE_BITS-1:0]   job_type;
   } req_type;

   typedef struct packed {
      logic                   done_res;
      logic [HANDLE_BITS-1:0] out_handle;
      logic [STEP_BITS-1:0]   out_step;
      logic [TYPE_BITS-1:0]   out_type;
      logic                   pool_full;
      logic [FLAG_BITS-1:0]   queue_nonempty;
   } rsp_type;

   // one pool slot
   typedef struct packed {
      logic [QSEL_BITS-1:0]   queue;
      logic [HANDLE_BITS-1:0] handle;
      logic [STEP_BITS-1:0]   step;
      logic [TYPE_BITS-1:0]   kind;
   } entry_type;

endpackage

`default_nettype wire

[hdl/mqpp_entry_ram.sv]
// mqpp_entry_ram: simple dual-port RAM, one write and one registered read port.
// Generic; no package dependency.
`default_nettype none

module mqpp_entry_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output      logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[hdl/multi_queue_priority_picker_core.sv]
// multi_queue_priority_picker_core: top level of the multi-queue priority picker.
// Uses mqpp_pkg and mqpp_entry_ram.
`default_nettype none

// Channel   Ports                          Direction  Beat
// -------   -----------------------------  ---------  --------------------------------
// request   req_valid/req_stall/req_payload in         one add or take command
// response  rsp_valid/rsp_stall/rsp_payload out        one result per request beat
//
// Path from accept to rsp_valid: an add writes its slot in ST_ADD; a take on
// an empty pool or a missing queue goes straight to ST_DONE. Otherwise a take
// scans the n used slots through the single read port and ends with no match,
// a match in the youngest slot, or m younger slots copied down one (ST_SHIFT).
// Reset clears the control state, the used count and per-queue counts; the pool
// RAM is never cleared, every slot below the used count has been written.
// One request is in work at a time; a result parked in the output register
// under rsp_stall does not block the next request beat.

module multi_queue_priority_picker_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire mqpp_pkg::req_type req_payload,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      mqpp_pkg::rsp_type rsp_payload
);

   import mqpp_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ADD    = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_SHIFT  = 3'd3;
   localparam logic [2:0] ST_REMOVE = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   localparam int ENTRY_W = $bits(entry_type);

   // control state
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] qcnt_ff [QUEUE_COUNT];
   logic [CNT_W-1:0] qcnt_in [QUEUE_COUNT];
   logic             issuing_ff, issuing_in;
   logic             pend_ff, pend_in;
   logic             pend_last_ff, pend_last_in;
   logic             found_ff, found_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload state
   req_type          req_ff, req_in;
   logic [IDX_W-1:0] issue_idx_ff, issue_idx_in;
   logic [IDX_W-1:0] last_idx_ff, last_idx_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [HANDLE_BITS-1:0] best_handle_ff, best_handle_in;
   logic [STEP_BITS-1:0]   best_step_ff, best_step_in;
   logic [TYPE_BITS-1:0]   best_kind_ff, best_kind_in;
   logic             res_done_ff, res_done_in;
   logic             res_full_ff, res_full_in;
   rsp_type          rsp_ff, rsp_in;

   // RAM port
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_entry;
   logic [IDX_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_bits;
   entry_type        rd_entry;

   logic             req_fire;
   logic             new_sel_ok;
   logic             sel_ok;
   logic             match;
   logic             better;
   logic             rsp_load;
   logic [FLAG_BITS-1:0] flags;

   mqpp_entry_ram #(
      .DEPTH (POOL_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_pool (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_entry  = entry_type'(rd_bits);
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign new_sel_ok = (32'(req_payload.queue_select) < QUEUE_COUNT);
   assign sel_ok     = (32'(req_ff.queue_select) < QUEUE_COUNT);

   // scan compare: higher step, then lower type; strict so the oldest keeps ties
   assign match  = pend_ff && (rd_entry.queue == req_ff.queue_select);
   assign better = !found_ff || (rd_entry.step > best_step_ff) ||
                   ((rd_entry.step == best_step_ff) && (rd_entry.kind < best_kind_ff));

   always_comb begin
      flags = '0;
      for (int i = 0; i < FLAG_COUNT; i++) begin
         flags[i] = (qcnt_ff[i] != '0);
      end
   end

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      qcnt_in        = qcnt_ff;
      issuing_in     = issuing_ff;
      pend_in        = 1'b0;
      pend_last_in   = pend_last_ff;
      pend_idx_in    = pend_idx_ff;
      found_in       = found_ff;
      req_in         = req_ff;
      issue_idx_in   = issue_idx_ff;
      last_idx_in    = last_idx_ff;
      best_idx_in    = best_idx_ff;
      best_handle_in = best_handle_ff;
      best_step_in   = best_step_ff;
      best_kind_in   = best_kind_ff;
      res_done_in    = res_done_ff;
      res_full_in    = res_full_ff;
      wr_en          = 1'b0;
      wr_addr        = IDX_W'(count_ff);
      wr_entry       = '{queue:  req_ff.queue_select,
                         handle: req_ff.job_handle,
                         step:   req_ff.job_step,
                         kind:   req_ff.job_type};
      rd_addr        = issue_idx_ff;

      // read issue, shared by scan and compaction
      if ((state_ff == ST_SCAN || state_ff == ST_SHIFT) && issuing_ff) begin
         pend_in      = 1'b1;
         pend_idx_in  = issue_idx_ff;
         pend_last_in = (issue_idx_ff == last_idx_ff);
         if (issue_idx_ff == last_idx_ff) begin
            issuing_in = 1'b0;
         end else begin
            issue_idx_in = issue_idx_ff + 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               req_in      = req_payload;
               found_in    = 1'b0;
               res_done_in = 1'b0;
               res_full_in = 1'b0;
               if (req_payload.operation == OP_ADD) begin
                  state_in = ST_ADD;
               end else if (new_sel_ok && count_ff != '0) begin
                  state_in     = ST_SCAN;
                  issuing_in   = 1'b1;
                  issue_idx_in = '0;
                  last_idx_in  = IDX_W'(count_ff - 1'b1);
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ADD: begin
            if (sel_ok) begin
               if (count_ff == CNT_W'(POOL_DEPTH)) begin
                  res_full_in = 1'b1;
               end else begin
                  wr_en       = 1'b1;
                  count_in    = count_ff + 1'b1;
                  res_done_in = 1'b1;
                  for (int i = 0; i < QUEUE_COUNT; i++) begin
                     if (32'(req_ff.queue_select) == i) begin
                        qcnt_in[i] = qcnt_ff[i] + 1'b1;
                     end
                  end
               end
            end
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (match && better) begin
               found_in       = 1'b1;
               best_idx_in    = pend_idx_ff;
               best_handle_in = rd_entry.handle;
               best_step_in   = rd_entry.step;
               best_kind_in   = rd_entry.kind;
            end
            if (pend_ff && pend_last_ff) begin
               if (!found_in) begin
                  state_in = ST_DONE;
               end else if (best_idx_in == last_idx_ff) begin
                  state_in = ST_REMOVE;
               end else begin
                  // move the younger entries down one slot
                  state_in     = ST_SHIFT;
                  issuing_in   = 1'b1;
                  issue_idx_in = best_idx_in + 1'b1;
               end
            end
         end
         ST_SHIFT: begin
            if (pend_ff) begin
               wr_en    = 1'b1;
               wr_addr  = pend_idx_ff - 1'b1;
               wr_entry = rd_entry;
               if (pend_last_ff) begin
                  state_in = ST_REMOVE;
               end
            end
         end
         ST_REMOVE: begin
            count_in    = count_ff - 1'b1;
            res_done_in = 1'b1;
            for (int i = 0; i < QUEUE_COUNT; i++) begin
               if (32'(req_ff.queue_select) == i) begin
                  qcnt_in[i] = qcnt_ff[i] - 1'b1;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in          = 1'b1;
         rsp_in.done_res       = res_done_ff;
         rsp_in.out_handle     = found_ff ? best_handle_ff : '0;
         rsp_in.out_step       = found_ff ? best_step_ff : '0;
         rsp_in.out_type       = found_ff ? best_kind_ff : '0;
         rsp_in.pool_full      = res_full_ff;
         rsp_in.queue_nonempty = flags;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         for (int i = 0; i < QUEUE_COUNT; i++) begin
            qcnt_ff[i] <= '0;
         end
         issuing_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         qcnt_ff      <= qcnt_in;
         issuing_ff   <= issuing_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      issue_idx_ff   <= issue_idx_in;
      last_idx_ff    <= last_idx_in;
      pend_idx_ff    <= pend_idx_in;
      best_idx_ff    <= best_idx_in;
      best_handle_ff <= best_handle_in;
      best_step_ff   <= best_step_in;
      best_kind_ff   <= best_kind_in;
      res_done_ff    <= res_done_in;
      res_full_ff    <= res_full_in;
      rsp_ff         <= rsp_in;
   end

endmodule

`default_nettype wire
